// File: hdl/assert_macros.svh
// Assertion macros shared by the buffer cache directory RTL.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lbct_pkg.sv
// Types and codes for the LRU buffer cache directory.
// Used by lbct_ctrl, lbct_dp and lru_buffer_cache_table; depends on nothing.
package lbct_pkg;

  localparam logic [1:0] FUNC_GET    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_PIN    = 2'd2;
  localparam logic [1:0] FUNC_UNPIN  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  device;
    logic [31:0] sector;
    logic [4:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       fetch;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: hdl/lbct_ctrl.sv
// Controller state machine for the buffer cache directory.
// Depends on lbct_pkg; drives the datapath commands, busy and the done strobe.
module lbct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output lbct_pkg::cmd_t    cmd
);

  lbct_pkg::state_t state;
  lbct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbct_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lbct_pkg::ST_IDLE: begin
        if (start) state_next = lbct_pkg::ST_EXEC;
      end
      lbct_pkg::ST_EXEC: begin
        state_next = lbct_pkg::ST_IDLE;
      end
      default: state_next = lbct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state)
      lbct_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      lbct_pkg::ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

// File: hdl/lbct_dp.sv
// Datapath of the buffer cache directory: tags, counts, recency line and result register.
// Depends on lbct_pkg; sequenced by lbct_ctrl through cmd_t.
module lbct_dp #(
  parameter int SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  lbct_pkg::cmd_t cmd,
  input  lbct_pkg::req_t req,
  output lbct_pkg::rsp_t rsp
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lbct_pkg::req_t r;
  logic [7:0]    tag_dev [SLOTS];
  logic [31:0]   tag_sec [SLOTS];
  logic [7:0]    cnt [SLOTS];
  logic [SW-1:0] order [SLOTS];
  logic [SLOTS-1:0] vld;

  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] pos_match;
  logic [SLOTS-1:0] pos_free;
  logic             hit_found;
  logic             free_found;
  logic [SW-1:0]    hit_pos;
  logic [SW-1:0]    free_pos;
  logic [SW-1:0]    spos;
  logic [SW-1:0]    hs;
  logic [SW-1:0]    fs;
  logic [SW-1:0]    sidx;
  logic             si_ok;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = (tag_dev[s] == r.device) && (tag_sec[s] == r.sector);
    end
    for (int p = 0; p < SLOTS; p++) begin
      pos_match[p] = match[order[p]];
      pos_free[p]  = (cnt[order[p]] == 8'd0);
    end
  end

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_pos    = '0;
    free_pos   = '0;
    spos       = '0;
    for (int p = SLOTS - 1; p >= 0; p--) begin
      if (pos_match[p]) begin
        hit_found = 1'b1;
        hit_pos   = SW'(p);
      end
    end
    for (int p = 0; p < SLOTS; p++) begin
      if (pos_free[p]) begin
        free_found = 1'b1;
        free_pos   = SW'(p);
      end
      if (order[p] == sidx) spos = SW'(p);
    end
  end

  assign hs    = order[hit_pos];
  assign fs    = order[free_pos];
  assign sidx  = SW'(r.slot_in);
  assign si_ok = 32'(r.slot_in) < 32'(SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        tag_dev[s] <= '1;
        tag_sec[s] <= '1;
        cnt[s]     <= '0;
        order[s]   <= SW'(SLOTS - 1 - s);
      end
    end else if (cmd.exec) begin
      rsp.slot   <= r.slot_in;
      rsp.hit    <= 1'b0;
      rsp.fetch  <= 1'b0;
      rsp.status <= lbct_pkg::STAT_OK;
      case (r.func)
        lbct_pkg::FUNC_GET: begin
          if (hit_found) begin
            rsp.slot <= 5'(hs);
            rsp.hit  <= 1'b1;
            if (cnt[hs] == lbct_pkg::CNT_MAX) begin
              rsp.status <= lbct_pkg::STAT_OVERFLOW;
            end else begin
              cnt[hs]   <= cnt[hs] + 8'd1;
              rsp.fetch <= ~vld[hs];
              vld[hs]   <= 1'b1;
            end
          end else if (free_found) begin
            rsp.slot   <= 5'(fs);
            rsp.fetch  <= 1'b1;
            tag_dev[fs] <= r.device;
            tag_sec[fs] <= r.sector;
            cnt[fs]    <= 8'd1;
            vld[fs]    <= 1'b1;
          end else begin
            rsp.slot   <= '0;
            rsp.status <= lbct_pkg::STAT_NO_FREE;
          end
        end
        lbct_pkg::FUNC_PIN: begin
          if (si_ok) begin
            if (cnt[sidx] == lbct_pkg::CNT_MAX) rsp.status <= lbct_pkg::STAT_OVERFLOW;
            else cnt[sidx] <= cnt[sidx] + 8'd1;
          end
        end
        lbct_pkg::FUNC_RELEASE, lbct_pkg::FUNC_UNPIN: begin
          if (si_ok) begin
            if (cnt[sidx] == 8'd0) begin
              rsp.status <= lbct_pkg::STAT_UNDERFLOW;
            end else begin
              cnt[sidx] <= cnt[sidx] - 8'd1;
              if (r.func == lbct_pkg::FUNC_RELEASE && cnt[sidx] == 8'd1) begin
                order[0] <= sidx;
                for (int p = 1; p < SLOTS; p++) begin
                  if (SW'(p) <= spos) order[p] <= order[p-1];
                end
              end
            end
          end
        end
        default: rsp.status <= lbct_pkg::STAT_OK;
      endcase
    end
  end

endmodule

// File: hdl/lru_buffer_cache_table.sv
// Top level of the LRU buffer cache directory.
// Depends on lbct_pkg, lbct_ctrl, lbct_dp and assert_macros.svh.
//
// Each request is registered at the accepting edge, and the next edge
// does the parallel tag compare, the recency-ordered hit and free-slot picks and the
// state update in one pass through the datapath. The result is registered and shown
// on rsp with done high for exactly one cycle; the receiver cannot stall it, and busy
// is already low in that cycle so the next request may be accepted. After reset the
// block is ready at once, with no clearing pass.
`include "assert_macros.svh"

module lru_buffer_cache_table #(
  parameter int SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lbct_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output lbct_pkg::rsp_t rsp
);

  lbct_pkg::cmd_t cmd;

  lbct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lbct_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted request did not go busy")
  `ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy cycle not followed by a result")
  `ASSERT_SAME(a_nofree, done && rsp.status == lbct_pkg::STAT_NO_FREE, rsp.slot == 5'd0 && !rsp.hit && !rsp.fetch, "no-free result carries slot or flags")
  `ASSERT_SAME(a_fetch_ok, done && rsp.fetch, rsp.status == lbct_pkg::STAT_OK, "fetch reported with error status")

endmodule
